// File: rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the CRC-32 packet framer
// Holds the channel payload types, the command word between the front and
// the back, header constants and the CRC-32/ISO-HDLC byte step.
// ----------------------------------------------------------------------------
package cpf_pkg;

    localparam int unsigned HEADER_BYTES    = 32;
    localparam int unsigned HDR_CRC_SPAN    = 28;
    localparam int unsigned TRAILER_BYTES   = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned IDX_W = $clog2(HEADER_BYTES);

    localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
    localparam logic [31:0] CRC_PRESET  = 32'hffff_ffff;
    localparam logic [7:0]  VERSION_RST = 8'd1;

    // Magic bytes 0x00 'C' '5' 'V' 'R' 'X' 0xa5 0x5a, little-endian packed.
    localparam logic [63:0] MAGIC_LE = 64'h5aa5_5852_5635_4300;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  packet_type;
        logic [31:0] payload_length;
        logic [62:0] timestamp;
        logic [7:0]  data_byte;
        logic        last_payload;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       packet_end;
    } t_out;

    // One queued job for the back: either a whole header or one payload byte.
    typedef struct packed {
        logic        is_hdr;
        logic [7:0]  version;
        logic [7:0]  packet_type;
        logic [31:0] seq;
        logic [31:0] payload_length;
        logic [62:0] timestamp;
        logic [7:0]  data_byte;
        logic        last;
    } t_cmd;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

endpackage

// File: rtl/cpf_front.sv
// ----------------------------------------------------------------------------
// cpf_front: input side of the packet framer
// Accepts input transfers, drops payload bytes outside a packet, assigns
// sequence numbers and turns each kept item into a command for the queue.
// ----------------------------------------------------------------------------
module cpf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    input  cpf_pkg::t_in  i_in_data,
    input  logic          i_q_full,
    output logic          o_push,
    output cpf_pkg::t_cmd o_cmd
);

    logic [7:0]  r_version;
    logic [31:0] r_seq;
    logic        r_in_packet;
    logic        accept;
    logic        is_start;

    assign is_start = (i_in_data.opcode == cpf_pkg::OP_START);
    assign accept   = i_in_valid && !i_q_full;
    assign o_push   = accept && (is_start || r_in_packet);

    always_comb begin
        o_cmd.is_hdr         = is_start;
        o_cmd.version        = r_version;
        o_cmd.packet_type    = i_in_data.packet_type;
        o_cmd.seq            = r_seq;
        o_cmd.payload_length = i_in_data.payload_length;
        o_cmd.timestamp      = i_in_data.timestamp;
        o_cmd.data_byte      = i_in_data.data_byte;
        o_cmd.last           = i_in_data.last_payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version   <= cpf_pkg::VERSION_RST;
            r_seq       <= '0;
            r_in_packet <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_version <= i_cfg_wdata;
            end
            if (accept && is_start) begin
                r_seq       <= r_seq + 32'd1;
                r_in_packet <= 1'b1;
            end else if (accept && r_in_packet && i_in_data.last_payload) begin
                r_in_packet <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/cpf_queue.sv
// ----------------------------------------------------------------------------
// cpf_queue: command queue between front and back
// A small first-in first-out buffer of commands with a combinational head.
// ----------------------------------------------------------------------------
module cpf_queue #(
    parameter int unsigned DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cpf_pkg::t_cmd o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cpf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/cpf_back.sv
// ----------------------------------------------------------------------------
// cpf_back: byte emitter of the packet framer
// Walks the head command one output byte per cycle while not stalled, folds
// the header and payload CRCs as bytes go out, and registers the output.
// ----------------------------------------------------------------------------
module cpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cpf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output cpf_pkg::t_out o_out_data
);

    localparam int unsigned IW = cpf_pkg::IDX_W;
    localparam logic [IW-1:0] HDR_LAST  = IW'(cpf_pkg::HEADER_BYTES - 1);
    localparam logic [IW-1:0] CRC_START = IW'(cpf_pkg::HDR_CRC_SPAN);
    localparam logic [IW-1:0] TRL_LAST  = IW'(cpf_pkg::TRAILER_BYTES);
    localparam logic [15:0]   HDR_SIZE  = 16'(cpf_pkg::HEADER_BYTES);

    logic [IW-1:0]  r_idx;
    logic [31:0]    r_hcrc;
    logic [31:0]    r_pcrc;
    logic           r_ovalid;
    cpf_pkg::t_out  r_out;

    logic           adv;
    logic [223:0]   hdr_vec;
    logic [31:0]    hcrc_inv;
    logic [31:0]    pcrc_inv;
    logic [31:0]    hcrc_base;
    logic [7:0]     hdr_byte;
    cpf_pkg::t_out  n_out;
    logic           done;

    assign adv = i_q_valid && (!r_ovalid || !i_out_stall);

    // Header bytes 0..27 laid out little-endian, byte k at bits [8k+7:8k].
    assign hdr_vec  = {1'b0, i_cmd.timestamp, i_cmd.payload_length, i_cmd.seq,
                       HDR_SIZE, i_cmd.packet_type, i_cmd.version, cpf_pkg::MAGIC_LE};
    assign hcrc_inv  = ~r_hcrc;
    assign pcrc_inv  = ~r_pcrc;
    assign hcrc_base = (r_idx == '0) ? cpf_pkg::CRC_PRESET : r_hcrc;

    always_comb begin
        hdr_byte = hdr_vec[{3'b000, r_idx} * 8 +: 8];
        if (r_idx >= CRC_START) begin
            hdr_byte = hcrc_inv[{r_idx[1:0], 3'b000} +: 8];
        end
    end

    always_comb begin
        n_out = '0;
        done  = 1'b0;
        if (i_cmd.is_hdr) begin
            n_out.out_byte    = hdr_byte;
            n_out.last_of_run = (r_idx == HDR_LAST);
            done              = (r_idx == HDR_LAST);
        end else if (r_idx == '0) begin
            n_out.out_byte    = i_cmd.data_byte;
            n_out.last_of_run = !i_cmd.last;
            done              = !i_cmd.last;
        end else begin
            // Trailer byte k sits at index k+1.
            n_out.out_byte    = pcrc_inv[{r_idx[1:0] - 2'd1, 3'b000} +: 8];
            n_out.last_of_run = (r_idx == TRL_LAST);
            n_out.packet_end  = (r_idx == TRL_LAST);
            done              = (r_idx == TRL_LAST);
        end
    end

    assign o_pop = adv && done;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_hcrc   <= cpf_pkg::CRC_PRESET;
            r_pcrc   <= cpf_pkg::CRC_PRESET;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
                r_idx    <= done ? '0 : r_idx + IW'(1);
                if (i_cmd.is_hdr) begin
                    if (r_idx < CRC_START) begin
                        r_hcrc <= cpf_pkg::crc_fold(hcrc_base, hdr_byte);
                    end
                    if (done) begin
                        r_pcrc <= cpf_pkg::CRC_PRESET;
                    end
                end else if (r_idx == '0) begin
                    r_pcrc <= cpf_pkg::crc_fold(r_pcrc, i_cmd.data_byte);
                end else if (done) begin
                    r_pcrc <= cpf_pkg::CRC_PRESET;
                end
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/crc32_packet_framer.sv
// ----------------------------------------------------------------------------
// crc32_packet_framer: CRC-32 framed packet byte stream builder
// Turns start and payload items into header, payload and trailer bytes.
// ----------------------------------------------------------------------------
// A start item produces a 32-byte header, one byte per unstalled cycle; a
// payload byte produces one output byte, and a final payload byte five (the
// byte and its 4-byte CRC trailer). The output side emits one byte per
// cycle while i_out_stall is low and sets the rate; the input side is taken
// one item per cycle as long as the command queue (QUEUE_DEPTH entries) has
// room, so a stream of payload bytes flows one per cycle while the output is
// not stalled; a header burst stalls input once the queue fills. Payload
// bytes that arrive outside a packet are accepted and dropped. The protocol
// version register is sampled into each start command when it is accepted.
module crc32_packet_framer #(
    parameter int unsigned QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cpf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cpf_pkg::t_out o_out_data
);

    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    cpf_pkg::t_cmd push_cmd;
    cpf_pkg::t_cmd head_cmd;

    assign o_in_stall = q_full;

    cpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    cpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/cpf_checker.sv
// ----------------------------------------------------------------------------
// cpf_checker: port-level checks of the packet framer
// Watches the output channel and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module cpf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input cpf_pkg::t_out o_out_data
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output data changed while stalled");

    // A packet can only end on the final byte of the transfer run.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.packet_end |-> o_out_data.last_of_run)
        else $error("packet end without last of run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind crc32_packet_framer cpf_checker u_cpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
